// ===== src/gaq_pkg.sv =====
// ----------------------------------------------------------------------------
// gaq_pkg
// Shared types and constants for the gas alarm qualifier: field widths,
// register indexes, status codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package gaq_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 12;
    localparam int TICK_BITS   = 32;
    localparam int HIT_BITS    = 8;
    localparam int POWER_BITS  = 16;
    localparam int CURR_BITS   = 15;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS = 3;

    // The write data port is as wide as the widest register.
    localparam int CFG_DATA_BITS = (TICK_BITS > POWER_BITS) ? TICK_BITS : POWER_BITS;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_BITS-1:0] GAS_THRESHOLD_RST = SAMPLE_BITS'(2048);
    localparam logic [HIT_BITS-1:0]    HITS_TO_ALARM_RST = HIT_BITS'(3);
    localparam logic [HIT_BITS-1:0]    IDLE_POLLS_RST    = HIT_BITS'(5);
    localparam logic [TICK_BITS-1:0]   WARMUP_TICKS_RST  = TICK_BITS'(900000);
    localparam logic [TICK_BITS-1:0]   WARM_BASE_RST     = '0;
    localparam logic [POWER_BITS-1:0]  POWER_MIN_RST     = POWER_BITS'(790);
    localparam logic [CURR_BITS-1:0]   CURRENT_MIN_RST   = CURR_BITS'(140);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAS_THRESHOLD = 3'd0,
        CFG_HITS_TO_ALARM = 3'd1,
        CFG_IDLE_POLLS    = 3'd2,
        CFG_WARMUP_TICKS  = 3'd3,
        CFG_WARM_BASE     = 3'd4,
        CFG_POWER_MIN     = 3'd5,
        CFG_CURRENT_MIN   = 3'd6
    } cfg_idx_t;

    // Poll status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_WARMING     = 3'd0,
        ST_POWER_LOW   = 3'd1,
        ST_CURRENT_LOW = 3'd2,
        ST_MON_FAULT   = 3'd3,
        ST_MONITORED   = 3'd4
    } status_t;

    // Configuration register contents.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] gas_threshold;
        logic [HIT_BITS-1:0]    hits_to_alarm;
        logic [HIT_BITS-1:0]    idle_polls_to_clear;
        logic [TICK_BITS-1:0]   warmup_ticks;
        logic [TICK_BITS-1:0]   warm_base_tick;
        logic [POWER_BITS-1:0]  power_min_mw;
        logic [CURR_BITS-1:0]   current_min_ma;
    } cfg_t;

    // One poll word.
    typedef struct packed {
        logic [TICK_BITS-1:0]   now_tick;
        logic [SAMPLE_BITS-1:0] gas_sample;
        logic                   sample_ok;
        logic [POWER_BITS-1:0]  pwr_mw;
        logic [CURR_BITS-1:0]   cur_ma;
        logic                   monitor_fault;
    } poll_t;

    // One result word.
    typedef struct packed {
        status_t             status;
        logic                warmup_done;
        logic                alarm;
        logic [HIT_BITS-1:0] hit_count;
    } result_t;

endpackage

// ===== src/gaq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gaq_cfg_regs
// Configuration register file: decodes the write port into the seven
// qualifier settings.
// ----------------------------------------------------------------------------
module gaq_cfg_regs
    import gaq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; an index beyond the list leaves everything as it was.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAS_THRESHOLD: cfg_next.gas_threshold       = cfg_data[SAMPLE_BITS-1:0];
                CFG_HITS_TO_ALARM: cfg_next.hits_to_alarm       = cfg_data[HIT_BITS-1:0];
                CFG_IDLE_POLLS:    cfg_next.idle_polls_to_clear = cfg_data[HIT_BITS-1:0];
                CFG_WARMUP_TICKS:  cfg_next.warmup_ticks        = cfg_data[TICK_BITS-1:0];
                CFG_WARM_BASE:     cfg_next.warm_base_tick      = cfg_data[TICK_BITS-1:0];
                CFG_POWER_MIN:     cfg_next.power_min_mw        = cfg_data[POWER_BITS-1:0];
                CFG_CURRENT_MIN:   cfg_next.current_min_ma      = cfg_data[CURR_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gas_threshold       <= GAS_THRESHOLD_RST;
            cfg_reg.hits_to_alarm       <= HITS_TO_ALARM_RST;
            cfg_reg.idle_polls_to_clear <= IDLE_POLLS_RST;
            cfg_reg.warmup_ticks        <= WARMUP_TICKS_RST;
            cfg_reg.warm_base_tick      <= WARM_BASE_RST;
            cfg_reg.power_min_mw        <= POWER_MIN_RST;
            cfg_reg.current_min_ma      <= CURRENT_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/gaq_qualify.sv =====
// ----------------------------------------------------------------------------
// gaq_qualify
// Poll qualification: warm-up tracking, sensor health checks, and the hit
// and inactivity counters. State advances when the caller commits a poll.
// ----------------------------------------------------------------------------
module gaq_qualify
    import gaq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  poll_t   poll,
    input  logic    commit,
    output result_t result
);

    logic                warmed_reg;
    logic                warmed_next;
    logic [HIT_BITS-1:0] hits_reg;
    logic [HIT_BITS-1:0] hits_next;
    logic [HIT_BITS-1:0] idle_reg;
    logic [HIT_BITS-1:0] idle_next;

    logic [TICK_BITS-1:0] elapsed;
    logic                 reached;
    logic                 warm;
    logic                 hit;
    logic [HIT_BITS-1:0]  hits_inc;
    logic [HIT_BITS-1:0]  hits_mid;
    logic [HIT_BITS-1:0]  idle_inc;
    logic                 alarm;
    status_t              status;

    // Warm-up check with wrap-around elapsed time.
    assign elapsed     = poll.now_tick - cfg.warm_base_tick;
    assign reached     = (elapsed >= cfg.warmup_ticks);
    assign warm        = warmed_reg | reached;
    assign warmed_next = warm;

    // Priority of the status checks.
    always_comb
    begin
        if (!warm)
            status = ST_WARMING;
        else if (poll.pwr_mw < cfg.power_min_mw)
            status = ST_POWER_LOW;
        else if (poll.cur_ma < cfg.current_min_ma)
            status = ST_CURRENT_LOW;
        else if (poll.monitor_fault)
            status = ST_MON_FAULT;
        else
            status = ST_MONITORED;
    end

    // Hit counting, alarm, and inactivity clearing.
    assign hit      = poll.sample_ok && (poll.gas_sample >= cfg.gas_threshold);
    assign hits_inc = hits_reg + HIT_BITS'(1);
    assign idle_inc = idle_reg + HIT_BITS'(1);

    always_comb
    begin
        alarm     = 1'b0;
        hits_mid  = hits_reg;
        hits_next = hits_reg;
        idle_next = idle_reg;
        if (status == ST_MONITORED)
        begin
            if (hit)
            begin
                if (hits_inc >= cfg.hits_to_alarm)
                begin
                    alarm    = 1'b1;
                    hits_mid = '0;
                end
                else
                begin
                    hits_mid = hits_inc;
                end
            end
            hits_next = hits_mid;
            if (hits_mid != '0)
            begin
                if (idle_inc >= cfg.idle_polls_to_clear)
                begin
                    idle_next = '0;
                    hits_next = '0;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
        end
    end

    // Counter state, advanced once per committed poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmed_reg <= 1'b0;
            hits_reg   <= '0;
            idle_reg   <= '0;
        end
        else if (commit)
        begin
            warmed_reg <= warmed_next;
            hits_reg   <= hits_next;
            idle_reg   <= idle_next;
        end
    end

    assign result.status      = status;
    assign result.warmup_done = reached & ~warmed_reg;
    assign result.alarm       = alarm;
    assign result.hit_count   = hits_next;

endmodule

// ===== src/gas_alarm_qualifier.sv =====
// ----------------------------------------------------------------------------
// gas_alarm_qualifier
// Qualifies gas sensor polls into alarm results.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | now_tick gas_sample sample_ok pwr_mw
//          |                     | cur_ma monitor_fault
//  out     | out_valid/out_ready | status warmup_done alarm hit_count
//  cfg     | cfg_we              | cfg_index cfg_data (write only)
//
// A poll is captured in the input register, evaluated combinationally, and
// its result lands in the output register.
// One poll is accepted every cycle as long as results are taken.
// Reset clears the warm-up flag, both counters and all valid flags, and
// loads the register defaults. A stalled output holds the pipeline; an empty
// input register still fills while the output word waits.
// ----------------------------------------------------------------------------
module gas_alarm_qualifier
    import gaq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [TICK_BITS-1:0]     now_tick,
    input  logic [SAMPLE_BITS-1:0]   gas_sample,
    input  logic                     sample_ok,
    input  logic [POWER_BITS-1:0]    pwr_mw,
    input  logic [CURR_BITS-1:0]     cur_ma,
    input  logic                     monitor_fault,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_BITS-1:0]   status,
    output logic                     warmup_done,
    output logic                     alarm,
    output logic [HIT_BITS-1:0]      hit_count
);

    cfg_t    cfg;
    poll_t   poll_reg;
    logic    poll_valid_reg;
    result_t res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    in_fire;

    gaq_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: a poll moves on when the output slot is free or being taken.
    assign advance  = poll_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !poll_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            poll_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            poll_reg.now_tick      <= now_tick;
            poll_reg.gas_sample    <= gas_sample;
            poll_reg.sample_ok     <= sample_ok;
            poll_reg.pwr_mw        <= pwr_mw;
            poll_reg.cur_ma        <= cur_ma;
            poll_reg.monitor_fault <= monitor_fault;
        end
    end

    gaq_qualify u_qualify
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .poll   (poll_reg),
        .commit (advance),
        .result (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = res_valid_reg;
    assign status      = res_reg.status;
    assign warmup_done = res_reg.warmup_done;
    assign alarm       = res_reg.alarm;
    assign hit_count   = res_reg.hit_count;

endmodule
